// ----- sv/msc_pkg.sv -----
package msc_pkg;

  localparam int AxisW  = 16;
  localparam int DiffW  = 17;
  localparam int StateW = 24;
  localparam int WeightW = 17;
  localparam int OpAW   = 18;
  localparam int OpBW   = 25;
  localparam int ProdW  = 43;
  localparam int AccW   = 44;
  localparam int RowW   = 48;
  localparam int CfgIdxW = 3;

  localparam logic [WeightW-1:0] WEIGHT_ONE = 17'd65536;

  typedef struct packed {
    logic signed [AxisW-1:0] sample_z;
    logic signed [AxisW-1:0] sample_y;
    logic signed [AxisW-1:0] sample_x;
  } msc_in_t;

  typedef struct packed {
    logic signed [AxisW-1:0] out_z;
    logic signed [AxisW-1:0] out_y;
    logic signed [AxisW-1:0] out_x;
  } msc_out_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SOFT_ROW0   = 3'd0,
    REG_SOFT_ROW1   = 3'd1,
    REG_SOFT_ROW2   = 3'd2,
    REG_HARD_OFFSET = 3'd3,
    REG_WEIGHT      = 3'd4,
    REG_FILTER_ON   = 3'd5,
    REG_CALIB_ON    = 3'd6
  } msc_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_FILT,
    ST_DRAIN,
    ST_DONE
  } msc_state_t;

  typedef enum logic {
    OP_CAL,
    OP_FILT
  } msc_op_t;

  typedef struct packed {
    logic       load_in;
    logic       op_valid;
    msc_op_t    op_kind;
    logic [1:0] row;
    logic [1:0] col;
    logic       load_out;
  } msc_cmd_t;

  typedef struct packed {
    logic calib_on;
    logic filter_on;
    logic seeded;
    logic out_free;
  } msc_status_t;

endpackage

// ----- sv/mag_calibrate_and_smooth.sv -----
// Channel   Payload      Handshake                   Direction
// sample    msc_in_t     sample_valid / sample_stall  in
// result    msc_out_t    result_valid / result_stall  out
// config    cfg_data     cfg_we, cfg_index            in
//
// With correction and smoothing both on and the filter seeded, an item goes through
// these steps: accept, nine multiply steps for the soft-iron matrix, six for the blend,
// a drain of the accumulator and a load of the result register. The multiply steps
// use the single shared 18x25 multiplier; with correction off the matrix steps are skipped.
// Reset is synchronous and restores the identity matrix and an unseeded filter.
// A stalled result holds in its register; the next item may be accepted meanwhile.
module mag_calibrate_and_smooth (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  msc_pkg::msc_in_t              sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output msc_pkg::msc_out_t             result,
  input  logic                          cfg_we,
  input  logic [msc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [msc_pkg::RowW-1:0]      cfg_data
);
  import msc_pkg::*;

  msc_cmd_t    cmd;
  msc_status_t status;

  msc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  msc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- sv/msc_ctrl.sv -----
module msc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  msc_pkg::msc_status_t status,
  output msc_pkg::msc_cmd_t    cmd
);
  import msc_pkg::*;

  msc_state_t state, state_next;
  logic [1:0] row, row_next;
  logic [1:0] col, col_next;
  logic       filt_pending;

  assign filt_pending = status.filter_on && status.seeded;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= 2'd0;
      col   <= 2'd0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
    end
  end

  always_comb begin
    state_next = state;
    row_next   = 2'd0;
    col_next   = 2'd0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          if (status.calib_on) state_next = ST_CAL;
          else if (filt_pending) state_next = ST_FILT;
          else state_next = ST_DRAIN;
        end
      end
      ST_CAL: begin
        if (row == 2'd2 && col == 2'd2) begin
          state_next = filt_pending ? ST_FILT : ST_DRAIN;
        end else if (col == 2'd2) begin
          row_next = row + 2'd1;
        end else begin
          row_next = row;
          col_next = col + 2'd1;
        end
      end
      ST_FILT: begin
        if (row == 2'd2 && col == 2'd1) begin
          state_next = ST_DRAIN;
        end else if (col == 2'd1) begin
          row_next = row + 2'd1;
        end else begin
          row_next = row;
          col_next = col + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sample_stall = 1'b1;
    cmd          = '0;
    cmd.op_kind  = OP_CAL;
    cmd.row      = row;
    cmd.col      = col;
    case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        cmd.load_in  = sample_valid;
      end
      ST_CAL: begin
        cmd.op_valid = 1'b1;
        cmd.op_kind  = OP_CAL;
      end
      ST_FILT: begin
        cmd.op_valid = 1'b1;
        cmd.op_kind  = OP_FILT;
      end
      ST_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        sample_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- sv/msc_dp.sv -----
module msc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [msc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [msc_pkg::RowW-1:0]          cfg_data,
  input  msc_pkg::msc_in_t                  sample,
  input  msc_pkg::msc_cmd_t                 cmd,
  output msc_pkg::msc_status_t              status,
  output logic                              result_valid,
  input  logic                              result_stall,
  output msc_pkg::msc_out_t                 result
);
  import msc_pkg::*;

  // Configuration registers.
  logic [RowW-1:0]    soft_row [3];
  logic [RowW-1:0]    hard;
  logic [WeightW-1:0] weight;
  logic               filter_on;
  logic               calib_on;

  // Per-item working registers.
  logic signed [DiffW-1:0]  d [3];
  logic signed [StateW-1:0] v [3];
  logic [WeightW-1:0]       w_new;
  logic [WeightW-1:0]       w_old;
  logic [WeightW-1:0]       w_clamp;

  // Filter state.
  logic signed [StateW-1:0] smooth [3];
  logic                     seeded;

  // Multiplier stage.
  logic signed [AxisW-1:0]  coef;
  logic signed [OpAW-1:0]   op_a;
  logic signed [OpBW-1:0]   op_b;
  logic signed [ProdW-1:0]  prod;
  logic                     p_valid;
  msc_op_t                  p_kind;
  logic [1:0]               p_row;
  logic [1:0]               p_col;

  // Accumulate stage.
  logic signed [AccW-1:0]   acc;
  logic signed [AccW-1:0]   p_ext;
  logic signed [AccW-1:0]   sum;
  logic signed [AccW-1:0]   sum_sh;
  logic signed [StateW-1:0] cal_val;

  logic signed [AxisW-1:0]  s_in [3];
  logic signed [AxisW-1:0]  off [3];
  logic signed [AxisW-1:0]  out_val [3];
  logic                     out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_row[0] <= 48'h0000_0000_4000;
      soft_row[1] <= 48'h0000_4000_0000;
      soft_row[2] <= 48'h4000_0000_0000;
      hard        <= '0;
      weight      <= 17'd19661;
      filter_on   <= 1'b1;
      calib_on    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOFT_ROW0:   soft_row[0] <= cfg_data;
        REG_SOFT_ROW1:   soft_row[1] <= cfg_data;
        REG_SOFT_ROW2:   soft_row[2] <= cfg_data;
        REG_HARD_OFFSET: hard        <= cfg_data;
        REG_WEIGHT:      weight      <= cfg_data[WeightW-1:0];
        REG_FILTER_ON:   filter_on   <= cfg_data[0];
        REG_CALIB_ON:    calib_on    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign s_in[0] = sample.sample_x;
  assign s_in[1] = sample.sample_y;
  assign s_in[2] = sample.sample_z;
  assign off[0]  = hard[15:0];
  assign off[1]  = hard[31:16];
  assign off[2]  = hard[47:32];
  assign w_clamp = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;

  // Operand selection for the shared multiplier.
  assign coef = soft_row[cmd.row][{cmd.col, 4'b0000} +: AxisW];

  always_comb begin
    if (cmd.op_kind == OP_CAL) begin
      op_a = {{(OpAW-AxisW){coef[AxisW-1]}}, coef};
      op_b = {{(OpBW-DiffW){d[cmd.col][DiffW-1]}}, d[cmd.col]};
    end else if (cmd.col == 2'd0) begin
      op_a = {1'b0, w_new};
      op_b = {v[cmd.row][StateW-1], v[cmd.row]};
    end else begin
      op_a = {1'b0, w_old};
      op_b = {smooth[cmd.row][StateW-1], smooth[cmd.row]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.op_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= op_a * op_b;
    p_kind <= cmd.op_kind;
    p_row  <= cmd.row;
    p_col  <= cmd.col;
  end

  assign p_ext  = {prod[ProdW-1], prod};
  assign sum    = acc + p_ext;
  assign sum_sh = sum >>> 6;

  always_comb begin
    if (sum_sh > 44'sd8388607) begin
      cal_val = 24'sh7FFFFF;
    end else if (sum_sh < -44'sd8388608) begin
      cal_val = 24'sh800000;
    end else begin
      cal_val = sum_sh[StateW-1:0];
    end
  end

  // The rounding constant is folded in with the first product of each dot product.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int i = 0; i < 3; i++) begin
        d[i] <= {s_in[i][AxisW-1], s_in[i]} - {off[i][AxisW-1], off[i]};
        v[i] <= {s_in[i], 8'h00};
      end
      w_new <= w_clamp;
      w_old <= WEIGHT_ONE - w_clamp;
    end else if (p_valid && p_kind == OP_CAL && p_col == 2'd2) begin
      v[p_row] <= cal_val;
    end
    if (p_valid) begin
      if (p_col == 2'd0) begin
        acc <= p_ext + ((p_kind == OP_CAL) ? 44'sd32 : 44'sd32768);
      end else begin
        acc <= sum;
      end
    end
  end

  // Filter state: updated by the blend, or seeded from the first item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) smooth[i] <= '0;
      seeded <= 1'b0;
    end else if (p_valid && p_kind == OP_FILT && p_col == 2'd1) begin
      smooth[p_row] <= sum[StateW+15:16];
    end else if (cmd.load_out && filter_on && !seeded) begin
      for (int i = 0; i < 3; i++) smooth[i] <= v[i];
      seeded <= 1'b1;
    end
  end

  always_comb begin
    logic signed [StateW-1:0] src;
    logic signed [StateW:0]   rs;
    logic signed [AxisW:0]    q;
    for (int i = 0; i < 3; i++) begin
      src = (filter_on && seeded) ? smooth[i] : v[i];
      rs  = {src[StateW-1], src} + 25'sd128;
      q   = rs[StateW:8];
      if (q > 17'sd32767) out_val[i] = 16'sh7FFF;
      else if (q < -17'sd32768) out_val[i] = 16'sh8000;
      else out_val[i] = q[AxisW-1:0];
    end
  end

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.out_x <= out_val[0];
      result.out_y <= out_val[1];
      result.out_z <= out_val[2];
    end
  end

  assign status.calib_on  = calib_on;
  assign status.filter_on = filter_on;
  assign status.seeded    = seeded;
  assign status.out_free  = out_free;

endmodule

// ----- sv/msc_check.sv -----
module msc_check (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input logic              result_valid,
  input logic              result_stall,
  input msc_pkg::msc_out_t result
);
  import msc_pkg::*;

  // A result waiting on a stalled receiver keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("item accepted while busy");

  // Reset leaves the block ready with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("block not idle after reset");

  // A fresh result only appears while an item was in work.
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result without item in work");

endmodule

bind mag_calibrate_and_smooth msc_check u_check (.*);
